// ===== hdl/tqi_pkg.sv =====
// Shared types and constants for the trapezoid quadratic integrator.
// Transaction structs, sequencer states, multiply-accumulate modes.
// No dependencies.
package tqi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int BOUND_W   = 24;
    localparam int DIFF_W    = BOUND_W + 1;
    localparam int SEG_W     = 16;
    localparam int MAXSEG_W  = 20;
    localparam logic [MAXSEG_W-1:0] MAX_SEGMENTS = 20'd65535;
    localparam int OUT_W     = 48;

    // Shared multiplier operand widths and accumulator width
    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W + MUL_B_W;

    // Trapezoid magnitude and signed running result
    localparam int MAG_W = 56;
    localparam int RES_W = 58;

    // Restoring divider
    localparam int DVD_W = 41;
    localparam int DVS_W = SEG_W;
    localparam logic [DVS_W-1:0] CORR_DIV = 16'd12;

    // End correction divide by twelve: 14-bit digits, reciprocal multiply per digit
    localparam int CDQ_W      = 42;
    localparam int CDIG_W     = 14;
    localparam int CDIGITS    = CDQ_W / CDIG_W;
    localparam int CREM_W     = 4;
    localparam int CT_W       = CREM_W + CDIG_W;
    localparam int CPROD_W    = 2 * CT_W;
    localparam logic [CT_W-1:0] CDIV_RECIP = 18'd174763;
    localparam int CDIV_SHIFT = 21;

    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    localparam logic [1:0] OP_SINGLE    = 2'd0;
    localparam logic [1:0] OP_COMPOSITE = 2'd1;
    localparam logic [1:0] OP_CORRECTED = 2'd2;

    typedef struct packed {
        logic [1:0]                op;
        logic signed [BOUND_W-1:0] lower_bound;
        logic signed [BOUND_W-1:0] upper_bound;
        logic [SEG_W-1:0]          segments;
    } in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] integral;
        logic                    error_flag;
        logic                    saturated;
    } out_t;

    typedef enum logic [2:0] {
        MAC_QUAD,
        MAC_QUAD2,
        MAC_PLAIN,
        MAC_SHL_A,
        MAC_SHL_B
    } mac_mode_t;

    typedef struct packed {
        logic      valid;
        logic      clear;
        mac_mode_t mode;
    } mac_ctl_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_ENDS_LO,
        ST_ENDS_HI,
        ST_SUM,
        ST_S_DRAIN,
        ST_HS_LO,
        ST_HS_HI,
        ST_HS_DRAIN,
        ST_HS_TAKE,
        ST_HH,
        ST_HH_DRAIN,
        ST_CD_LO,
        ST_CD_HI,
        ST_CD_DRAIN,
        ST_CDIV_GO,
        ST_CDIV_WAIT,
        ST_SAT,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/tqi_mac.sv =====
// Shared multiply-accumulate unit: registered 24x25 product, then a shifted
// add into the accumulator. Depends on tqi_pkg.
module tqi_mac
    import tqi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  mac_ctl_t           ctl,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic [ACC_W-1:0]   acc
);

    logic [PROD_W-1:0] prod_reg;
    mac_ctl_t          ctl_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic [ACC_W-1:0]  term;
    logic [ACC_W-1:0]  base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        acc_reg  <= acc_next;
    end

    // Square terms drop their fraction before the add, as each point is floored
    always_comb
    begin
        case (ctl_reg.mode)
            MAC_QUAD:  term = ACC_W'(prod_reg >> FRAC_BITS);
            MAC_QUAD2: term = ACC_W'(prod_reg >> FRAC_BITS) << 1;
            MAC_PLAIN: term = ACC_W'(prod_reg);
            MAC_SHL_A: term = ACC_W'(prod_reg) << MUL_A_W;
            MAC_SHL_B: term = ACC_W'(prod_reg) << MUL_B_W;
            default:   term = '0;
        endcase
    end

    assign base     = ctl_reg.clear ? '0 : acc_reg;
    assign acc_next = ctl_reg.valid ? base + term : acc_reg;
    assign acc      = acc_reg;

endmodule

// ===== hdl/tqi_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on tqi_pkg.
module tqi_div
    import tqi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W:0]   trial;
    logic             fits;
    logic [DVS_W:0]   diff;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/trapezoid_quadratic_integrator.sv =====
// Trapezoid quadratic integrator: sequencer around a shared multiply-accumulate
// unit and a restoring divider. Depends on tqi_pkg, tqi_mac, tqi_div.
//
// Integrates x^2 + 4x + 4 between two signed Q8.16 bounds.
// Command channel: drive request and raise start; the transaction is taken at a
// clock edge where start is high and busy is low. busy stays high until the
// result has been shown.
// Result channel: done is high for exactly one cycle with result valid; the
// receiver takes it then and cannot hold it off, so nothing ever stalls.
// Operations: op 0 single trapezoid, op 1 composite, op 2 end-corrected.
// Op 3, or op 1 or 2 with zero segments after the clamp, ends with error_flag set.
// The inner-point loop issues one square per cycle into the shared 24x25
// multiplier; the step comes from the one-bit-per-cycle divider, and the
// divide by twelve of the end correction works through three 14-bit digits.
// One transaction is in flight at a time; busy drops in the cycle after done.
// Reset returns the sequencer to idle; an unfinished transaction is dropped.
module trapezoid_quadratic_integrator
    import tqi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  in_t  request,
    output logic done,
    output out_t result
);

    state_t state_reg;
    state_t state_next;

    logic [1:0]                op_reg, op_next;
    logic signed [BOUND_W-1:0] lo_reg, lo_next;
    logic signed [BOUND_W-1:0] hi_reg, hi_next;
    logic [SEG_W-1:0]          n_reg, n_next;
    logic signed [DIFF_W-1:0]  h_reg, h_next;
    logic signed [BOUND_W-1:0] x_reg, x_next;
    logic [SEG_W-1:0]          cnt_reg, cnt_next;
    logic signed [RES_W-1:0]   res_reg, res_next;
    logic [CDQ_W-1:0]          cq_reg, cq_next;
    logic [CREM_W-1:0]         cr_reg, cr_next;
    out_t                      result_reg, result_next;

    logic [SEG_W-1:0]          seg_clamped;
    logic                      err;
    logic signed [DIFF_W-1:0]  diff;
    logic                      diff_neg;
    logic [MUL_A_W-1:0]        diff_mag;
    logic [MUL_B_W-1:0]        d_mag;
    logic [MUL_A_W-1:0]        h_mag;
    logic signed [DIFF_W-1:0]  h_from_q;
    logic signed [DIFF_W-1:0]  x_step;
    logic signed [BOUND_W-1:0] quad_x;
    logic signed [DIFF_W-1:0]  quad_t;
    logic [MUL_A_W-1:0]        quad_mag;
    logic [ACC_W-1:0]          hs_shift;
    logic [ACC_W-1:0]          cd_shift;
    logic [MAG_W-1:0]          mag;
    logic                      sat_hi;
    logic                      sat_lo;
    logic [CT_W-1:0]           c_t;
    logic [CPROD_W-1:0]        c_prod;
    logic [CDIG_W-1:0]         c_digit;
    logic [CT_W-1:0]           c_back;

    mac_ctl_t           mac_ctl;
    logic [MUL_A_W-1:0] mac_a;
    logic [MUL_B_W-1:0] mac_b;
    logic [ACC_W-1:0]   acc;

    logic               div_go;
    logic [DVD_W-1:0]   div_dividend;
    logic [DVS_W-1:0]   div_divisor;
    logic               div_done;
    logic [DVD_W-1:0]   div_quotient;

    tqi_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a     (mac_a),
        .b     (mac_b),
        .acc   (acc)
    );

    tqi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Hold the segment count at its ceiling
    assign seg_clamped = ({{(MAXSEG_W-SEG_W){1'b0}}, request.segments} > MAX_SEGMENTS)
                       ? MAX_SEGMENTS[SEG_W-1:0] : request.segments;

    assign err = (op_reg == OP_SINGLE) ? 1'b0
               : ((op_reg == OP_COMPOSITE) || (op_reg == OP_CORRECTED)) ? (n_reg == '0)
               : 1'b1;

    assign diff     = {hi_reg[BOUND_W-1], hi_reg} - {lo_reg[BOUND_W-1], lo_reg};
    assign diff_neg = diff[DIFF_W-1];
    assign diff_mag = diff_neg ? MUL_A_W'(-diff) : MUL_A_W'(diff);
    assign d_mag    = {diff_mag, 1'b0};
    assign h_mag    = h_reg[DIFF_W-1] ? MUL_A_W'(-h_reg) : MUL_A_W'(h_reg);

    // Step truncates toward zero: divide the magnitude, then restore the sign
    assign h_from_q = diff_neg ? -$signed(div_quotient[DIFF_W-1:0])
                               : $signed(div_quotient[DIFF_W-1:0]);

    assign quad_t   = {quad_x[BOUND_W-1], quad_x} + DIFF_W'(2 << FRAC_BITS);
    assign quad_mag = quad_t[DIFF_W-1] ? MUL_A_W'(-quad_t) : MUL_A_W'(quad_t);

    assign hs_shift = acc >> (FRAC_BITS + 1);
    assign mag      = hs_shift[MAG_W-1:0];
    assign cd_shift = acc >> (2 * FRAC_BITS);

    // Divide by twelve one digit at a time: the reciprocal gives the digit,
    // the remainder carries into the next digit
    assign c_t     = {cr_reg, cq_reg[CDQ_W-1 -: CDIG_W]};
    assign c_prod  = CPROD_W'(c_t) * CPROD_W'(CDIV_RECIP);
    assign c_digit = c_prod[CDIV_SHIFT +: CDIG_W];
    assign c_back  = c_t - CT_W'(c_digit) * CT_W'(CORR_DIV);

    assign sat_hi = !res_reg[RES_W-1] && (res_reg[RES_W-2:OUT_W-1] != '0);
    assign sat_lo = res_reg[RES_W-1] && (res_reg[RES_W-2:OUT_W-1] != '1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (start) state_next = ST_SETUP;
            ST_SETUP:
            begin
                if (err)
                begin
                    state_next = ST_DONE;
                end
                else if (op_reg == OP_SINGLE)
                begin
                    state_next = ST_ENDS_LO;
                end
                else
                begin
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO:    state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:  if (div_done) state_next = ST_ENDS_LO;
            ST_ENDS_LO:   state_next = ST_ENDS_HI;
            ST_ENDS_HI:   state_next = ST_SUM;
            ST_SUM:       if (cnt_reg == '0) state_next = ST_S_DRAIN;
            ST_S_DRAIN:   state_next = ST_HS_LO;
            ST_HS_LO:     state_next = ST_HS_HI;
            ST_HS_HI:     state_next = ST_HS_DRAIN;
            ST_HS_DRAIN:  state_next = ST_HS_TAKE;
            ST_HS_TAKE:   state_next = (op_reg == OP_CORRECTED) ? ST_HH : ST_SAT;
            ST_HH:        state_next = ST_HH_DRAIN;
            ST_HH_DRAIN:  state_next = ST_CD_LO;
            ST_CD_LO:     state_next = ST_CD_HI;
            ST_CD_HI:     state_next = ST_CD_DRAIN;
            ST_CD_DRAIN:  state_next = ST_CDIV_GO;
            ST_CDIV_GO:   state_next = ST_CDIV_WAIT;
            ST_CDIV_WAIT: if (cnt_reg == '0) state_next = ST_SAT;
            ST_SAT:       state_next = ST_DONE;
            ST_DONE:      state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        op_next      = op_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        n_next       = n_reg;
        h_next       = h_reg;
        x_next       = x_reg;
        cnt_next     = cnt_reg;
        res_next     = res_reg;
        cq_next      = cq_reg;
        cr_next      = cr_reg;
        result_next  = result_reg;
        mac_ctl      = '{valid: 1'b0, clear: 1'b0, mode: MAC_PLAIN};
        mac_a        = '0;
        mac_b        = '0;
        quad_x       = x_reg;
        x_step       = {x_reg[BOUND_W-1], x_reg} + h_reg;
        div_go       = 1'b0;
        div_dividend = DVD_W'(diff_mag);
        div_divisor  = n_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next = request.op;
                    lo_next = request.lower_bound;
                    hi_next = request.upper_bound;
                    n_next  = seg_clamped;
                end
            end
            ST_SETUP:
            begin
                h_next      = diff;
                cnt_next    = '0;
                result_next = '{integral: '0, error_flag: 1'b1, saturated: 1'b0};
            end
            ST_DIV_GO:
            begin
                div_go = 1'b1;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    h_next   = h_from_q;
                    x_step   = {lo_reg[BOUND_W-1], lo_reg} + h_from_q;
                    x_next   = x_step[BOUND_W-1:0];
                    cnt_next = n_reg - SEG_W'(1);
                end
            end
            ST_ENDS_LO:
            begin
                quad_x  = lo_reg;
                mac_ctl = '{valid: 1'b1, clear: 1'b1, mode: MAC_QUAD};
                mac_a   = quad_mag;
                mac_b   = {1'b0, quad_mag};
            end
            ST_ENDS_HI:
            begin
                quad_x  = hi_reg;
                mac_ctl = '{valid: 1'b1, clear: 1'b0, mode: MAC_QUAD};
                mac_a   = quad_mag;
                mac_b   = {1'b0, quad_mag};
            end
            ST_SUM:
            begin
                // Inner points count twice; advance x by one step per cycle
                if (cnt_reg != '0)
                begin
                    mac_ctl  = '{valid: 1'b1, clear: 1'b0, mode: MAC_QUAD2};
                    mac_a    = quad_mag;
                    mac_b    = {1'b0, quad_mag};
                    x_next   = x_step[BOUND_W-1:0];
                    cnt_next = cnt_reg - SEG_W'(1);
                end
            end
            ST_HS_LO:
            begin
                mac_ctl = '{valid: 1'b1, clear: 1'b1, mode: MAC_PLAIN};
                mac_a   = h_mag;
                mac_b   = acc[MUL_B_W-1:0];
            end
            ST_HS_HI:
            begin
                mac_ctl = '{valid: 1'b1, clear: 1'b0, mode: MAC_SHL_B};
                mac_a   = h_mag;
                mac_b   = MUL_B_W'(acc[PROD_W-1:MUL_B_W]);
            end
            ST_HS_TAKE:
            begin
                res_next = h_reg[DIFF_W-1] ? RES_W'(0) - {2'b00, mag} : {2'b00, mag};
            end
            ST_HH:
            begin
                mac_ctl = '{valid: 1'b1, clear: 1'b1, mode: MAC_PLAIN};
                mac_a   = h_mag;
                mac_b   = {1'b0, h_mag};
            end
            ST_CD_LO:
            begin
                mac_ctl = '{valid: 1'b1, clear: 1'b1, mode: MAC_PLAIN};
                mac_a   = acc[MUL_A_W-1:0];
                mac_b   = d_mag;
            end
            ST_CD_HI:
            begin
                mac_ctl = '{valid: 1'b1, clear: 1'b0, mode: MAC_SHL_A};
                mac_a   = acc[2*MUL_A_W-1:MUL_A_W];
                mac_b   = d_mag;
            end
            ST_CDIV_GO:
            begin
                cq_next  = cd_shift[CDQ_W-1:0];
                cr_next  = '0;
                cnt_next = SEG_W'(CDIGITS);
            end
            ST_CDIV_WAIT:
            begin
                if (cnt_reg != '0)
                begin
                    cq_next  = {cq_reg[CDQ_W-CDIG_W-1:0], c_digit};
                    cr_next  = c_back[CREM_W-1:0];
                    cnt_next = cnt_reg - SEG_W'(1);
                end
                else
                begin
                    // Subtract the correction with the sign of the slope difference
                    res_next = diff_neg ? res_reg + RES_W'(cq_reg)
                                        : res_reg - RES_W'(cq_reg);
                end
            end
            ST_SAT:
            begin
                result_next.error_flag = 1'b0;
                result_next.saturated  = sat_hi || sat_lo;
                if (sat_hi)
                begin
                    result_next.integral = OUT_MAX;
                end
                else if (sat_lo)
                begin
                    result_next.integral = OUT_MIN;
                end
                else
                begin
                    result_next.integral = res_reg[OUT_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        n_reg      <= n_next;
        h_reg      <= h_next;
        x_reg      <= x_next;
        cnt_reg    <= cnt_next;
        res_reg    <= res_next;
        cq_reg     <= cq_next;
        cr_reg     <= cr_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = (state_reg == ST_DONE);
    assign result = result_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.error_flag |-> (result.integral == '0) && !result.saturated)
        else $error("error result carries a value");

    a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.saturated |->
            (result.integral == OUT_MAX) || (result.integral == OUT_MIN))
        else $error("saturated result not at a range end");

endmodule
